/* hw/rtl/sti_pkg.sv */
// Shared types and constants for the sorted key table.
`default_nettype none
package sti_pkg;

	localparam int KEY_W = 31;
	localparam int POS_W = 10;
	localparam int CNT_W = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam logic METHOD_LINEAR = 1'b0;
	localparam logic METHOD_BINARY = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b1;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd1024;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_INS_CMP = 7'b0000010,
		ST_PLACE   = 7'b0000100,
		ST_LIN_CMP = 7'b0001000,
		ST_BIN_RD  = 7'b0010000,
		ST_BIN_CMP = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

/* hw/rtl/sorted_table_insert_search_unit.sv */
// One item in flight: a request is not taken until the last result has been loaded; out_valid rises
// as in_ready returns, and a result still waiting in the output register stalls the final state.
// Sorted insert shifts each larger entry up before placing the key; unsorted insert places it at
// the end; searches compare through the shared key comparator; errors go straight to the result.
// Reset (arst_n low) empties the table, sets sorted mode and capacity 1024; no clearing pass.
`default_nettype none
module sorted_table_insert_search_unit #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [sti_pkg::KEY_W-1:0]     key,
	input  wire logic                          search_method,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               status,
	output logic                               found,
	output logic [sti_pkg::POS_W-1:0]          position,
	output logic [sti_pkg::CNT_W-1:0]          op_count,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sti_pkg::CNT_W-1:0]     cfg_data
);
	import sti_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

	logic [KEY_W-1:0] key_store [TABLE_DEPTH];

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hp1_q;
	logic [CW-1:0]    op_q;
	logic [CW-1:0]    count_q;
	logic             sorted_mode_q;
	logic [CNT_W-1:0] capacity_q;
	logic             res_status_q;
	logic             res_found_q;
	logic [AW-1:0]    res_pos_q;
	logic             out_valid_q;
	logic             status_q;
	logic             found_q;
	logic [POS_W-1:0] position_q;
	logic [CNT_W-1:0] op_count_q;
	logic [KEY_W-1:0] rd_data_q;

	logic             in_fire;
	logic             cmp_gt;
	logic             cmp_eq;
	logic             full;
	logic             table_empty;
	logic [CW-1:0]    count_m1;
	logic [CW-1:0]    lin_next;
	logic             lin_last;
	logic [CW:0]      mid_sum;
	logic [AW-1:0]    mid;
	logic             bin_open;
	logic             fin_load;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// shared comparator: memory word against the request key
	assign cmp_gt = rd_data_q > key_q;
	assign cmp_eq = rd_data_q == key_q;

	assign full = (CMPW'(count_q) >= CMPW'(capacity_q)) || (count_q == CW'(TABLE_DEPTH));
	assign table_empty = (count_q == '0);
	assign count_m1 = count_q - CW'(1);
	assign lin_next = CW'(ptr_q) + CW'(1);
	assign lin_last = (lin_next == count_q);
	assign mid_sum  = (CW+1)'(lo_q) + (CW+1)'(hp1_q) - (CW+1)'(1);
	assign mid      = AW'(mid_sum >> 1);
	assign bin_open = lo_q < hp1_q;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = key_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && req_type == REQ_INSERT && !full && sorted_mode_q && !table_empty) begin
					rd_en   = 1'b1;
					rd_addr = AW'(count_m1);
				end else if (in_fire && req_type == REQ_SEARCH && !table_empty
						&& search_method == METHOD_LINEAR) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ST_INS_CMP: begin
				// shift the larger entry up and prefetch the one below it
				if (cmp_gt) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
					if (ptr_q != AW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = ptr_q - AW'(2);
					end
				end
			end
			ST_PLACE: begin
				wr_en = 1'b1;
			end
			ST_LIN_CMP: begin
				if (!cmp_eq && !lin_last) begin
					rd_en   = 1'b1;
					rd_addr = AW'(lin_next);
				end
			end
			ST_BIN_RD: begin
				if (bin_open) begin
					rd_en   = 1'b1;
					rd_addr = mid;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_store[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= key_store[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			sorted_mode_q <= 1'b1;
			capacity_q    <= CAPACITY_RESET;
			out_valid_q   <= 1'b0;
			key_q         <= '0;
			ptr_q         <= '0;
			lo_q          <= '0;
			hp1_q         <= '0;
			op_q          <= '0;
			res_status_q  <= STATUS_OK;
			res_found_q   <= 1'b0;
			res_pos_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SORTED_MODE: sorted_mode_q <= cfg_data[0];
					CFG_CAPACITY:    capacity_q    <= cfg_data;
					default: begin
					end
				endcase
			end

			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						key_q        <= key;
						op_q         <= '0;
						res_status_q <= STATUS_OK;
						res_found_q  <= 1'b0;
						res_pos_q    <= '0;
						if (req_type == REQ_INSERT) begin
							ptr_q <= AW'(count_q);
							if (full) begin
								res_status_q <= STATUS_ERR;
								state_q      <= ST_FIN;
							end else if (sorted_mode_q && !table_empty) begin
								state_q <= ST_INS_CMP;
							end else begin
								state_q <= ST_PLACE;
							end
						end else begin
							ptr_q <= '0;
							lo_q  <= '0;
							hp1_q <= count_q;
							if (table_empty || (search_method == METHOD_BINARY && !sorted_mode_q)) begin
								res_status_q <= STATUS_ERR;
								state_q      <= ST_FIN;
							end else if (search_method == METHOD_LINEAR) begin
								state_q <= ST_LIN_CMP;
							end else begin
								state_q <= ST_BIN_RD;
							end
						end
					end
				end
				ST_INS_CMP: begin
					if (cmp_gt) begin
						ptr_q <= ptr_q - AW'(1);
						op_q  <= op_q + CW'(1);
						if (ptr_q == AW'(1)) begin
							state_q <= ST_PLACE;
						end
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_LIN_CMP: begin
					op_q <= op_q + CW'(1);
					if (cmp_eq) begin
						res_found_q <= 1'b1;
						res_pos_q   <= ptr_q;
						state_q     <= ST_FIN;
					end else if (lin_last) begin
						state_q <= ST_FIN;
					end else begin
						ptr_q <= AW'(lin_next);
					end
				end
				ST_BIN_RD: begin
					if (bin_open) begin
						ptr_q   <= mid;
						state_q <= ST_BIN_CMP;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_BIN_CMP: begin
					op_q <= op_q + CW'(1);
					if (cmp_eq) begin
						res_found_q <= 1'b1;
						res_pos_q   <= ptr_q;
						state_q     <= ST_FIN;
					end else begin
						if (cmp_gt) begin
							hp1_q <= CW'(ptr_q);
						end else begin
							lo_q <= CW'(ptr_q) + CW'(1);
						end
						state_q <= ST_BIN_RD;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			status_q   <= res_status_q;
			found_q    <= res_found_q;
			position_q <= POS_W'(res_pos_q);
			op_count_q <= CNT_W'(op_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign position  = position_q;
	assign op_count  = op_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write hit the same entry");

	a_count_only_on_place: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == ST_PLACE))
		else $error("entry count changed outside placement");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == STATUS_OK))
		else $error("found reported with error status");
`endif

endmodule
`default_nettype wire

/* dv/tb_sorted_table_insert_search_unit.sv */
// Testbench for the sorted key table: directed table walk, random phases, shadow-model checking.
module tb_sorted_table_insert_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sti_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned RANDOM_ITEMS = 560;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	typedef struct packed {
		logic             status;
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] op_count;
	} table_result_t;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CNT_W-1:0]     reg_data;
		logic                 rq;
		logic [KEY_W-1:0]     k;
		logic                 meth;
		logic                 typed;
		table_result_t        want;
	} dir_row_t;

	localparam table_result_t NO_RESULT = '0;
	localparam table_result_t RES_ERR = '{STATUS_ERR, 1'b0, 10'd0, 11'd0};
	localparam table_result_t RES_OK = '{STATUS_OK, 1'b0, 10'd0, 11'd0};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic [KEY_W-1:0]     key;
	logic                 search_method;
	logic                 out_valid;
	logic                 out_ready;
	logic                 status;
	logic                 found;
	logic [POS_W-1:0]     position;
	logic [CNT_W-1:0]     op_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	sorted_table_insert_search_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.key          (key),
		.search_method(search_method),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found        (found),
		.position     (position),
		.op_count     (op_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// shadow copy of the table and its registers
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	int unsigned      shadow_count = 0;
	logic             shadow_sorted = 1'b1;
	logic [CNT_W-1:0] shadow_capacity = CAPACITY_RESET;

	table_result_t pending_results [$];
	int unsigned   mismatch_count = 0;
	int unsigned   quiet_cycles = 0;
	bit            in_idle_on = 1'b1;
	bit            out_idle_on = 1'b1;

	dir_row_t directed_rows [29] = '{
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd5, METHOD_LINEAR, 1'b1, RES_ERR},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd0, METHOD_BINARY, 1'b1, RES_ERR},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd100, METHOD_LINEAR, 1'b1, RES_OK},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, KEY_MAX, METHOD_BINARY, 1'b1, RES_OK},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b1,
			'{STATUS_OK, 1'b0, 10'd0, 11'd2}},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd50, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd0, METHOD_LINEAR, 1'b1,
			'{STATUS_OK, 1'b1, 10'd0, 11'd1}},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, KEY_MAX, METHOD_BINARY, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd7, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd7, METHOD_BINARY, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd50, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REG, CFG_CAPACITY, 11'd6, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd1, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd2, METHOD_LINEAR, 1'b1, RES_ERR},
		'{ROW_REG, CFG_CAPACITY, 11'd0, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd3, METHOD_LINEAR, 1'b1, RES_ERR},
		'{ROW_REG, CFG_CAPACITY, 11'd3, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, KEY_MAX, METHOD_LINEAR, 1'b1, RES_ERR},
		'{ROW_REG, CFG_CAPACITY, 11'd2047, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REG, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd50, METHOD_BINARY, 1'b1, RES_ERR},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd10, METHOD_LINEAR, 1'b1, RES_OK},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, KEY_MAX, METHOD_LINEAR, 1'b1, RES_OK},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd10, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REG, CFG_SORTED_MODE, 11'd1, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, 31'd10, METHOD_BINARY, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_INSERT, 31'd5, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REQ, CFG_SORTED_MODE, 11'd0, REQ_SEARCH, KEY_MAX, METHOD_LINEAR, 1'b0, NO_RESULT},
		'{ROW_REG, CFG_CAPACITY, 11'd1024, REQ_INSERT, 31'd0, METHOD_LINEAR, 1'b0, NO_RESULT}
	};

	function automatic table_result_t predict_table_op(logic rq, logic [KEY_W-1:0] k,
			logic meth);
		table_result_t r;
		int unsigned   limit;
		int unsigned   slot;
		int unsigned   moves;
		int unsigned   cmps;
		int            lo;
		int            hi;
		int            mid;
		r = '0;
		if (rq == REQ_INSERT) begin
			limit = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
			if (shadow_count >= limit) begin
				r.status = STATUS_ERR;
				return r;
			end
			slot = shadow_count;
			moves = 0;
			if (shadow_sorted) begin
				while (slot > 0 && shadow_keys[slot - 1] > k) begin
					shadow_keys[slot] = shadow_keys[slot - 1];
					slot--;
					moves++;
				end
			end
			shadow_keys[slot] = k;
			shadow_count++;
			r.op_count = moves[CNT_W-1:0];
			return r;
		end
		if (shadow_count == 0 || (meth == METHOD_BINARY && !shadow_sorted)) begin
			r.status = STATUS_ERR;
			return r;
		end
		cmps = 0;
		if (meth == METHOD_LINEAR) begin
			for (slot = 0; slot < shadow_count; slot++) begin
				cmps++;
				if (shadow_keys[slot] == k) begin
					r.found = 1'b1;
					r.position = slot[POS_W-1:0];
					r.op_count = cmps[CNT_W-1:0];
					return r;
				end
			end
		end else begin
			lo = 0;
			hi = int'(shadow_count) - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				cmps++;
				if (shadow_keys[mid] == k) begin
					r.found = 1'b1;
					r.position = mid[POS_W-1:0];
					r.op_count = cmps[CNT_W-1:0];
					return r;
				end
				if (shadow_keys[mid] > k)
					hi = mid - 1;
				else
					lo = mid + 1;
			end
		end
		r.op_count = cmps[CNT_W-1:0];
		return r;
	endfunction

	function automatic int unsigned draw_wait(bit on);
		return on ? $urandom_range(0, 18) : 0;
	endfunction

	// favor keys already stored so searches hit and inserts hit duplicates
	function automatic logic [KEY_W-1:0] pick_key(int unsigned stored_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (shadow_count != 0 && roll < stored_pct)
			return shadow_keys[$urandom_range(0, shadow_count - 1)];
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return KEY_MAX;
		if (roll < 4)
			return KEY_W'($urandom_range(0, 63));
		return KEY_W'($urandom());
	endfunction

	function automatic logic [CNT_W-1:0] pick_capacity();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 11'd1;
			2: return CNT_W'(shadow_count / 2);
			3: return CAPACITY_RESET;
			4: return {CNT_W{1'b1}};
			5: return CNT_W'($urandom_range(0, 2047));
			default: return CNT_W'(shadow_count + $urandom_range(0, 40));
		endcase
	endfunction

	task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_request(logic rq, logic [KEY_W-1:0] k, logic meth, logic typed,
			table_result_t want);
		int unsigned   gap;
		table_result_t predicted;
		gap = draw_wait(in_idle_on);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq;
		key <= k;
		search_method <= meth;
		do @(posedge clk); while (!in_ready);
		predicted = predict_table_op(rq, k, meth);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// registers change only with nothing in flight
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SORTED_MODE)
			shadow_sorted = data[0];
		else
			shadow_capacity = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned   stall;
		table_result_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(out_idle_on);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending: op_count", op_count, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					note_mismatch("status", status, want.status);
				if (found !== want.found)
					note_mismatch("found", found, want.found);
				if (position !== want.position)
					note_mismatch("position", position, want.position);
				if (op_count !== want.op_count)
					note_mismatch("op_count", op_count, want.op_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_sorted_table_insert_search_unit: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned      issued;
		int unsigned      phase_len;
		logic             rq;
		logic             meth;
		logic [KEY_W-1:0] k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		key = '0;
		search_method = METHOD_LINEAR;
		cfg_valid = 1'b0;
		cfg_index = CFG_SORTED_MODE;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG)
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
			else
				push_request(directed_rows[i].rq, directed_rows[i].k, directed_rows[i].meth,
					directed_rows[i].typed, directed_rows[i].want);
		end

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			in_idle_on = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			// upper data bits of the mode write are don't-care
			if ($urandom_range(0, 9) < 7)
				write_register(CFG_SORTED_MODE,
					(CNT_W'($urandom_range(0, 2047)) & ~CNT_W'(1)) |
					CNT_W'($urandom_range(0, 3) != 0));
			if ($urandom_range(0, 9) < 7)
				write_register(CFG_CAPACITY, pick_capacity());
			phase_len = $urandom_range(20, 50);
			if (phase_len > RANDOM_ITEMS - issued)
				phase_len = RANDOM_ITEMS - issued;
			repeat (phase_len) begin
				rq = ($urandom_range(0, 99) < 48) ? REQ_INSERT : REQ_SEARCH;
				meth = 1'($urandom_range(0, 1));
				k = pick_key((rq == REQ_SEARCH) ? 55 : 15);
				push_request(rq, k, meth, 1'b0, NO_RESULT);
				issued++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_sorted_table_insert_search_unit: done, clean");
		else
			$display("tb_sorted_table_insert_search_unit: done, errors");
		$finish;
	end

endmodule
